@@ hw/rtl/thtd_pkg.sv @@
// ============================================================================
// thtd_pkg : shared types and constants of the tap/hold detector
// request and result payloads, event codes, register indexes and the
// per-button status record passed from the front end to the back end
// ============================================================================
package thtd_pkg;

    // event codes returned in event_res
    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_TAP_R  = 3'd1;
    localparam logic [2:0] EV_TAP_S  = 3'd2;
    localparam logic [2:0] EV_HOLD_R = 3'd3;
    localparam logic [2:0] EV_HOLD_S = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [1:0] CFG_HOLD_R   = 2'd1;
    localparam logic [1:0] CFG_HOLD_S   = 2'd2;

    // reset values of the configuration registers
    localparam logic [7:0]  DEBOUNCE_RST = 8'd25;
    localparam logic [15:0] HOLD_RST     = 16'd600;

    typedef struct packed {
        logic        raw_pressed_r;
        logic        raw_pressed_s;
        logic [31:0] now_ms;
    } in_req_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [15:0] hold_progress_r;
        logic [15:0] hold_progress_s;
    } out_res_t;

    // what one button did during one request
    typedef struct packed {
        logic        tap;
        logic        hold;
        logic [15:0] progress;
    } btn_status_t;

    // one classified request waiting for the event queue
    typedef struct packed {
        btn_status_t r;
        btn_status_t s;
    } cls_entry_t;

endpackage

@@ hw/rtl/thtd_button.sv @@
// ============================================================================
// thtd_button : debounce and tap/hold classification of one button
// holds the debounced level, change and press times and the hold flag,
// and reports tap, hold and hold progress for each accepted request
// ============================================================================
module thtd_button
    import thtd_pkg::*;
#(
    parameter int TIME_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,
    input  logic                  raw,
    input  logic [TIME_WIDTH-1:0] now,
    input  logic [7:0]            debounce_time,
    input  logic [15:0]           hold_time,
    output btn_status_t           status
);

    logic                  pressed_reg;
    logic                  pressed_next;
    logic                  reported_reg;
    logic                  reported_next;
    logic [TIME_WIDTH-1:0] last_change_reg;
    logic [TIME_WIDTH-1:0] last_change_next;
    logic [TIME_WIDTH-1:0] press_start_reg;
    logic [TIME_WIDTH-1:0] press_start_next;

    logic                  change;
    logic                  new_press;
    logic [TIME_WIDTH-1:0] since_change;
    logic [TIME_WIDTH-1:0] since_press;
    logic                  reported_mid;
    logic                  hold_hit;

    always_comb
    begin
        since_change = now - last_change_reg;
        change       = (raw != pressed_reg) &&
                       (since_change >= TIME_WIDTH'(debounce_time));
        new_press    = change && raw;

        pressed_next     = change ? raw : pressed_reg;
        last_change_next = change ? now : last_change_reg;
        press_start_next = new_press ? now : press_start_reg;
        reported_mid     = new_press ? 1'b0 : reported_reg;

        // a fresh press starts at now, so its elapsed time is zero
        since_press = new_press ? '0 : (now - press_start_reg);
        hold_hit    = pressed_next && !reported_mid &&
                      (since_press >= TIME_WIDTH'(hold_time));
        reported_next = reported_mid || hold_hit;

        status.tap  = change && !raw && !reported_reg;
        status.hold = hold_hit;
        // without a hold the elapsed time is below the hold time already
        if (!pressed_next || reported_next)
        begin
            status.progress = '0;
        end
        else
        begin
            status.progress = since_press[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg     <= 1'b0;
            reported_reg    <= 1'b0;
            last_change_reg <= '0;
            press_start_reg <= '0;
        end
        else if (take)
        begin
            pressed_reg     <= pressed_next;
            reported_reg    <= reported_next;
            last_change_reg <= last_change_next;
            press_start_reg <= press_start_next;
        end
    end

    a_tap_hold_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(status.tap && status.hold))
        else $error("tap and hold in the same request");

    a_hold_only_when_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        (take && status.hold) |=> (pressed_reg && reported_reg))
        else $error("hold reported without a pressed, flagged button");

endmodule

@@ hw/rtl/thtd_queue.sv @@
// ============================================================================
// thtd_queue : two-entry queue between classifier and event back end
// lets the front end keep accepting while the back end is stalled
// ============================================================================
module thtd_queue
    import thtd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  cls_entry_t push_entry,
    output logic       pop_valid,
    input  logic       pop_ready,
    output cls_entry_t pop_entry
);

    cls_entry_t slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= 2'd2) && ((count_reg == 2'd1) == (wr_ptr_reg != rd_ptr_reg)))
        else $error("queue count disagrees with its pointers");

endmodule

@@ hw/rtl/thtd_back.sv @@
// ============================================================================
// thtd_back : event fifo and result register
// queues up to two events per request, drops them when full, dequeues the
// oldest one and registers the result
// ============================================================================
module thtd_back
    import thtd_pkg::*;
#(
    parameter int FIFO_DEPTH = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cls_valid,
    output logic       cls_ready,
    input  cls_entry_t cls_entry,
    output logic       out_valid,
    input  logic       out_ready,
    output out_res_t   out_data
);

    // two banks so that two consecutive slots land in different banks
    localparam int CAP        = FIFO_DEPTH - 1;
    localparam int BANK_DEPTH = (FIFO_DEPTH + 1) / 2;
    localparam int PHYS       = 2 * BANK_DEPTH;
    localparam int PW         = $clog2(PHYS);
    localparam int RW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int CW         = $clog2(FIFO_DEPTH);
    localparam logic [CW-1:0] CAP_W  = CW'(CAP);
    localparam logic [PW:0]   PHYS_W = (PW + 1)'(PHYS);

    logic [2:0]    bank0_reg [BANK_DEPTH];
    logic [2:0]    bank1_reg [BANK_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          out_valid_reg;
    out_res_t      out_data_reg;
    out_res_t      out_data_next;

    logic          take;
    logic [2:0]    ev_r;
    logic [2:0]    ev_s;
    logic          want_r;
    logic          want_s;
    logic          acc_r;
    logic          acc_s;
    logic [CW-1:0] cnt_mid;
    logic [CW-1:0] cnt_all;
    logic          wr_a;
    logic          wr_b;
    logic [2:0]    ev_a;
    logic [PW-1:0] slot_b;
    logic [PW:0]   sum_b;
    logic [PW:0]   sum_wr;
    logic [PW:0]   sum_rd;
    logic [RW-1:0] row_a;
    logic [RW-1:0] row_b;
    logic [RW-1:0] row_rd;
    logic [2:0]    head_ev;
    logic          pop;

    assign cls_ready = !out_valid_reg || out_ready;
    assign take      = cls_valid && cls_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        ev_r   = cls_entry.r.tap ? EV_TAP_R : (cls_entry.r.hold ? EV_HOLD_R : EV_NONE);
        ev_s   = cls_entry.s.tap ? EV_TAP_S : (cls_entry.s.hold ? EV_HOLD_S : EV_NONE);
        want_r = cls_entry.r.tap || cls_entry.r.hold;
        want_s = cls_entry.s.tap || cls_entry.s.hold;

        // first button is pushed first, each push dropped when full
        acc_r   = want_r && (count_reg < CAP_W);
        cnt_mid = count_reg + CW'(acc_r);
        acc_s   = want_s && (cnt_mid < CAP_W);
        cnt_all = cnt_mid + CW'(acc_s);

        wr_a = acc_r || acc_s;
        wr_b = acc_r && acc_s;
        ev_a = acc_r ? ev_r : ev_s;

        sum_b  = {1'b0, wr_ptr_reg} + (PW + 1)'(1);
        slot_b = (sum_b >= PHYS_W) ? PW'(sum_b - PHYS_W) : PW'(sum_b);

        row_a  = RW'(wr_ptr_reg >> 1);
        row_b  = RW'(slot_b >> 1);
        row_rd = RW'(rd_ptr_reg >> 1);

        head_ev = rd_ptr_reg[0] ? bank1_reg[row_rd] : bank0_reg[row_rd];

        // an empty fifo hands this request's first event straight through
        pop = (cnt_all != '0);
        out_data_next.event_res = (count_reg != '0) ? head_ev :
                                  (wr_a ? ev_a : EV_NONE);
        out_data_next.hold_progress_r = cls_entry.r.progress;
        out_data_next.hold_progress_s = cls_entry.s.progress;

        sum_wr = {1'b0, wr_ptr_reg} + (PW + 1)'(wr_a) + (PW + 1)'(wr_b);
        wr_ptr_next = (sum_wr >= PHYS_W) ? PW'(sum_wr - PHYS_W) : PW'(sum_wr);
        sum_rd = {1'b0, rd_ptr_reg} + (PW + 1)'(pop);
        rd_ptr_next = (sum_rd >= PHYS_W) ? PW'(sum_rd - PHYS_W) : PW'(sum_rd);
        count_next  = cnt_all - CW'(pop);
    end

    // slot a and slot b always sit in different banks
    always_ff @(posedge clk)
    begin
        if (take && wr_a)
        begin
            if (wr_ptr_reg[0])
            begin
                bank1_reg[row_a] <= ev_a;
            end
            else
            begin
                bank0_reg[row_a] <= ev_a;
            end
        end
        if (take && wr_b)
        begin
            if (slot_b[0])
            begin
                bank1_reg[row_b] <= ev_s;
            end
            else
            begin
                bank0_reg[row_b] <= ev_s;
            end
        end
        if (take)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                wr_ptr_reg <= wr_ptr_next;
                rd_ptr_reg <= rd_ptr_next;
                count_reg  <= count_next;
            end
            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_W)
        else $error("event fifo holds more than its capacity");

    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        ((wr_ptr_reg >= rd_ptr_reg) ?
            (PW + 1)'(wr_ptr_reg - rd_ptr_reg) :
            ((PW + 1)'(wr_ptr_reg) + PHYS_W - (PW + 1)'(rd_ptr_reg)))
        == (PW + 1)'(count_reg))
        else $error("event fifo pointers disagree with its count");

    a_empty_none: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (count_reg == '0) && !want_r && !want_s)
        |=> (out_data_reg.event_res == EV_NONE))
        else $error("event returned from an empty fifo");

endmodule

@@ hw/rtl/two_button_tap_hold_detector_core.sv @@
// ============================================================================
// two_button_tap_hold_detector_core : debounced tap/hold detector, two buttons
// debounces two button levels against a millisecond time, classifies taps
// and holds, queues the events and returns one event and both buttons'
// hold progress for every poll request
// ============================================================================
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+------------------------------
//   in       | request   | in_valid / in_ready   | in_data  (levels, now_ms)
//   out      | result    | out_valid / out_ready | out_data (event, progress x2)
//   cfg      | write     | cfg_write             | cfg_index, cfg_data
//
// one request per cycle while in_ready is high; a result is registered in turn
// (classify into the queue, then event fifo into the result register)
// the two-entry queue and the result register let the input keep flowing
// while out_ready is low until both are full, then in_ready drops
// rst_n is asynchronous: button state, queue and event fifo pointers clear,
// configuration returns to debounce 25 ms and hold 600 ms; no clearing pass
// ============================================================================
module two_button_tap_hold_detector_core
    import thtd_pkg::*;
#(
    parameter int FIFO_DEPTH = 8,
    parameter int TIME_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // poll requests
    input  logic        in_valid,
    output logic        in_ready,
    input  in_req_t     in_data,
    // results
    output logic        out_valid,
    input  logic        out_ready,
    output out_res_t    out_data,
    // configuration writes
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // configuration registers
    logic [7:0]  debounce_reg;
    logic [7:0]  debounce_next;
    logic [15:0] hold_r_reg;
    logic [15:0] hold_r_next;
    logic [15:0] hold_s_reg;
    logic [15:0] hold_s_next;

    logic                  take;
    logic [TIME_WIDTH-1:0] now;
    cls_entry_t            cls_in;
    logic                  q_valid;
    logic                  q_ready;
    cls_entry_t            q_entry;

    // register decode, unknown index is ignored
    always_comb
    begin
        debounce_next = debounce_reg;
        hold_r_next   = hold_r_reg;
        hold_s_next   = hold_s_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_DEBOUNCE: debounce_next = cfg_data[7:0];
                CFG_HOLD_R:   hold_r_next   = cfg_data;
                CFG_HOLD_S:   hold_s_next   = cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RST;
            hold_r_reg   <= HOLD_RST;
            hold_s_reg   <= HOLD_RST;
        end
        else
        begin
            debounce_reg <= debounce_next;
            hold_r_reg   <= hold_r_next;
            hold_s_reg   <= hold_s_next;
        end
    end

    // front end: each accepted request updates both buttons at once,
    // first button's events ahead of the second's in the entry
    assign take = in_valid && in_ready;
    assign now  = in_data.now_ms[TIME_WIDTH-1:0];

    thtd_button #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_button_r (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .raw           (in_data.raw_pressed_r),
        .now           (now),
        .debounce_time (debounce_reg),
        .hold_time     (hold_r_reg),
        .status        (cls_in.r)
    );

    thtd_button #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_button_s (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .raw           (in_data.raw_pressed_s),
        .now           (now),
        .debounce_time (debounce_reg),
        .hold_time     (hold_s_reg),
        .status        (cls_in.s)
    );

    // classified requests wait here while the result side is stalled
    thtd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_entry (cls_in),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_entry  (q_entry)
    );

    // back end: event fifo push/pop and the result register
    thtd_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cls_valid (q_valid),
        .cls_ready (q_ready),
        .cls_entry (q_entry),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

@@ test/two_button_tap_hold_detector_core_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// two_button_tap_hold_detector_core_tb : self-checking bench of the detector
// drives poll requests with random gaps, drains results under random stalls
// and compares every result field against a cycle-free model of the debounce,
// tap/hold classification and event fifo, kept in step at each request
// ============================================================================
module two_button_tap_hold_detector_core_tb;
    import thtd_pkg::*;

    // index with no register behind it, writes must be ignored
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int EVENT_SLOTS = 8;
    localparam int MAX_GAP = 16;
    // idle clocks added once every outstanding result is back
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT = 200000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_req_t     in_data;
    logic        out_valid;
    logic        out_ready;
    out_res_t    out_data;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    two_button_tap_hold_detector_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // low first, so the first rising edge comes after reset is driven
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // detector model: configuration, per-button debounce state, event fifo
    // ------------------------------------------------------------------------
    logic [7:0]  cfg_debounce;
    logic [15:0] cfg_hold [2];
    logic        btn_down [2];
    logic [31:0] last_change [2];
    logic [31:0] press_start [2];
    logic        hold_seen [2];
    logic [2:0]  event_slots [EVENT_SLOTS];
    logic [2:0]  event_rd;
    logic [2:0]  event_wr;

    // results predicted for accepted requests, oldest first
    out_res_t    expected_polls [$];
    int          error_count;
    int          cycle_count;
    // stretches with no idling on either side
    bit          poll_burst;
    bit          drain_burst;

    // one slot stays empty, so a push that would catch the read pointer is lost
    task automatic queue_event(input logic [2:0] ev);
        logic [2:0] nxt;
        nxt = event_wr + 3'd1;
        if (nxt != event_rd)
        begin
            event_slots[event_wr] = ev;
            event_wr = nxt;
        end
    endtask

    task automatic service_button(input int b, input logic raw, input logic [31:0] now);
        logic [31:0] since_change;
        logic [31:0] since_press;
        since_change = now - last_change[b];
        // level change goes through once the button has been quiet long enough
        if (raw != btn_down[b] && since_change >= {24'd0, cfg_debounce})
        begin
            btn_down[b] = raw;
            last_change[b] = now;
            if (raw)
            begin
                press_start[b] = now;
                hold_seen[b] = 1'b0;
            end
            else if (!hold_seen[b])
            begin
                queue_event(b == 0 ? EV_TAP_R : EV_TAP_S);
            end
        end
        // hold is judged after the level update, so a release wins over a hold
        since_press = now - press_start[b];
        if (btn_down[b] && !hold_seen[b] && since_press >= {16'd0, cfg_hold[b]})
        begin
            hold_seen[b] = 1'b1;
            queue_event(b == 0 ? EV_HOLD_R : EV_HOLD_S);
        end
    endtask

    function automatic logic [15:0] hold_progress(input int b, input logic [31:0] now);
        logic [31:0] held;
        if (!btn_down[b] || hold_seen[b])
            return 16'd0;
        held = now - press_start[b];
        if (held > {16'd0, cfg_hold[b]})
            held = {16'd0, cfg_hold[b]};
        return held[15:0];
    endfunction

    // both buttons first, then one event leaves the fifo
    task automatic predict_poll(input in_req_t req);
        out_res_t res;
        service_button(0, req.raw_pressed_r, req.now_ms);
        service_button(1, req.raw_pressed_s, req.now_ms);
        res.event_res = EV_NONE;
        if (event_rd != event_wr)
        begin
            res.event_res = event_slots[event_rd];
            event_rd = event_rd + 3'd1;
        end
        res.hold_progress_r = hold_progress(0, req.now_ms);
        res.hold_progress_s = hold_progress(1, req.now_ms);
        expected_polls.push_back(res);
    endtask

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------
    // in_valid stays up when the next request follows with no gap
    task automatic send_poll(input logic r, input logic s, input logic [31:0] now);
        in_req_t req;
        int      gap;
        req.raw_pressed_r = r;
        req.raw_pressed_s = s;
        req.now_ms = now;
        gap = poll_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        predict_poll(req);
    endtask

    // stop requesting and let every outstanding result come back
    task automatic wait_idle(input int extra);
        in_valid <= 1'b0;
        while (expected_polls.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        wait_idle(SETTLE_CYCLES);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_DEBOUNCE: cfg_debounce = data[7:0];
            CFG_HOLD_R:   cfg_hold[0] = data;
            CFG_HOLD_S:   cfg_hold[1] = data;
            default:      ;  // unmapped index, nothing changes
        endcase
    endtask

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------
    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    task automatic check_result(input out_res_t got);
        out_res_t want;
        if (expected_polls.size() == 0)
        begin
            $display("%0t: result with no request outstanding, expected none, got event %0d",
                     $time, got.event_res);
            error_count++;
        end
        else
        begin
            want = expected_polls.pop_front();
            compare_field("event_res", 32'(want.event_res), 32'(got.event_res));
            compare_field("hold_progress_r", 32'(want.hold_progress_r),
                          32'(got.hold_progress_r));
            compare_field("hold_progress_s", 32'(want.hold_progress_s),
                          32'(got.hold_progress_s));
        end
    endtask

    // draws a stall before every result, out_ready stays up across back-to-back ones
    initial
    begin : result_sink
        int stall;
        forever
        begin
            stall = drain_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            check_result(out_data);
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("two_button_tap_hold_detector_core_tb: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // reset settings: bounce inside the debounce window, taps, exact boundary
    task automatic test_taps_and_bounce();
        send_poll(1'b0, 1'b0, 32'd1000);
        send_poll(1'b1, 1'b0, 32'd1010);
        send_poll(1'b0, 1'b0, 32'd1020);  // bounce, rejected
        send_poll(1'b0, 1'b1, 32'd1040);  // tap r, s pressed
        send_poll(1'b0, 1'b0, 32'd1050);  // too soon for s
        send_poll(1'b0, 1'b0, 32'd1065);  // exactly the debounce time, tap s
    endtask

    // both holds in one request, no tap after a hold, hold across time wrap
    task automatic test_hold_and_time_wrap();
        send_poll(1'b1, 1'b1, 32'd2000);
        send_poll(1'b1, 1'b1, 32'd2599);
        send_poll(1'b1, 1'b1, 32'd2600);
        send_poll(1'b0, 1'b0, 32'd2700);
        send_poll(1'b1, 1'b0, 32'hFFFF_FFFF);
        send_poll(1'b1, 1'b0, 32'd16);
        send_poll(1'b1, 1'b0, 32'd599);
        send_poll(1'b0, 1'b0, 32'd700);
    endtask

    // zero debounce and zero hold: press reports hold at once, same-time release
    task automatic test_zero_settings();
        write_reg(CFG_DEBOUNCE, 16'd0);
        write_reg(CFG_HOLD_R, 16'd0);
        write_reg(CFG_HOLD_S, 16'd0);
        send_poll(1'b1, 1'b1, 32'd5000);
        send_poll(1'b0, 1'b0, 32'd5000);
        send_poll(1'b1, 1'b0, 32'd5000);
        send_poll(1'b0, 1'b0, 32'd5000);
    endtask

    // upper data bits dropped, unmapped index ignored, asymmetric holds
    task automatic test_register_writes();
        write_reg(CFG_DEBOUNCE, 16'hFF05);
        write_reg(CFG_UNUSED, 16'hFFFF);
        write_reg(CFG_HOLD_R, 16'hFFFF);
        write_reg(CFG_HOLD_S, 16'd1);
        send_poll(1'b1, 1'b1, 32'd6000);
        send_poll(1'b0, 1'b1, 32'd6003);
        send_poll(1'b0, 1'b1, 32'd6005);
    endtask

    // largest settings; a release at the hold instant still gives a tap
    task automatic test_extreme_settings();
        write_reg(CFG_DEBOUNCE, 16'h00FF);
        write_reg(CFG_HOLD_R, 16'hFFFF);
        write_reg(CFG_HOLD_S, 16'hFFFF);
        send_poll(1'b1, 1'b0, 32'd7000);
        send_poll(1'b1, 1'b1, 32'd7300);
        send_poll(1'b1, 1'b1, 32'd7000 + 32'd65535);
        send_poll(1'b0, 1'b0, 32'd7300 + 32'd65535);
    endtask

    // each phase its own settings; time mostly moves forward in steps around
    // the debounce and hold windows, with the odd jump and random levels
    // note: every request drains one event and a button gives at most one
    // event per press, so the event fifo never fills from the ports
    task automatic test_random_polls();
        logic [31:0] now_t;
        logic        lvl_r;
        logic        lvl_s;
        int          span;
        for (int phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(CFG_DEBOUNCE, {8'd0, DEBOUNCE_RST});
                    write_reg(CFG_HOLD_R, HOLD_RST);
                    write_reg(CFG_HOLD_S, HOLD_RST);
                end
                1:
                begin
                    write_reg(CFG_DEBOUNCE, 16'd0);
                    write_reg(CFG_HOLD_R, 16'd0);
                    write_reg(CFG_HOLD_S, 16'd0);
                end
                2:
                begin
                    write_reg(CFG_DEBOUNCE, 16'h00FF);
                    write_reg(CFG_HOLD_R, 16'hFFFF);
                    write_reg(CFG_HOLD_S, 16'hFFFF);
                end
                3:
                begin
                    write_reg(CFG_DEBOUNCE, 16'($urandom_range(0, 40)));
                    write_reg(CFG_HOLD_R, 16'($urandom_range(0, 300)));
                    write_reg(CFG_HOLD_S, 16'($urandom_range(0, 300)));
                end
                4:
                begin
                    write_reg(CFG_DEBOUNCE, 16'($urandom_range(0, 65535)));
                    write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
                    write_reg(CFG_HOLD_R, 16'($urandom_range(0, 65535)));
                    write_reg(CFG_HOLD_S, 16'($urandom_range(0, 65535)));
                end
                5:
                begin
                    write_reg(CFG_DEBOUNCE, 16'd3);
                    write_reg(CFG_HOLD_R, 16'd1);
                    write_reg(CFG_HOLD_S, 16'd50);
                end
                default:
                begin
                    write_reg(CFG_DEBOUNCE, 16'($urandom_range(0, 8)));
                    write_reg(CFG_HOLD_R, 16'($urandom_range(0, 40)));
                    write_reg(CFG_HOLD_S, 16'($urandom_range(0, 40)));
                end
            endcase
            poll_burst = ($urandom_range(0, 3) == 0);
            drain_burst = ($urandom_range(0, 3) == 0);
            span = int'((cfg_hold[0] > cfg_hold[1]) ? cfg_hold[0] : cfg_hold[1]);
            span = span + 2;
            now_t = $urandom();
            lvl_r = 1'($urandom_range(0, 1));
            lvl_s = 1'($urandom_range(0, 1));
            for (int i = 0; i < 62; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    // noise: time jumps anywhere, levels at random
                    now_t = $urandom();
                    lvl_r = 1'($urandom_range(0, 1));
                    lvl_s = 1'($urandom_range(0, 1));
                end
                else
                begin
                    case ($urandom_range(0, 3))
                        0:       now_t = now_t + $urandom_range(0, cfg_debounce);
                        1:       now_t = now_t + cfg_debounce + $urandom_range(0, 20);
                        2:       now_t = now_t + $urandom_range(0, span + span / 4);
                        default: now_t = now_t + $urandom_range(0, 1);
                    endcase
                    if ($urandom_range(0, 2) == 0)
                        lvl_r = !lvl_r;
                    if ($urandom_range(0, 2) == 0)
                        lvl_s = !lvl_s;
                end
                send_poll(lvl_r, lvl_s, now_t);
            end
        end
    endtask

    initial
    begin : main_sequence
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        cfg_write <= 1'b0;
        cfg_index <= CFG_DEBOUNCE;
        cfg_data <= '0;
        error_count = 0;
        poll_burst = 1'b0;
        drain_burst = 1'b0;
        // model state after reset
        cfg_debounce = DEBOUNCE_RST;
        cfg_hold[0] = HOLD_RST;
        cfg_hold[1] = HOLD_RST;
        for (int b = 0; b < 2; b++)
        begin
            btn_down[b] = 1'b0;
            last_change[b] = '0;
            press_start[b] = '0;
            hold_seen[b] = 1'b0;
        end
        event_rd = '0;
        event_wr = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_taps_and_bounce();
        test_hold_and_time_wrap();
        test_zero_settings();
        test_register_writes();
        test_extreme_settings();
        test_random_polls();

        wait_idle(SETTLE_CYCLES);
        if (error_count == 0)
            $display("two_button_tap_hold_detector_core_tb: clean");
        else
            $display("two_button_tap_hold_detector_core_tb: errors");
        $finish;
    end

endmodule
